FILE: src/ssd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssd_pkg
// Shared constants, types and the digit code table for the seven-segment
// number formatter.
// ----------------------------------------------------------------------------
package ssd_pkg;

    localparam int MAX_DIGITS     = 8;
    localparam int C_MAG_W        = 16;
    localparam int C_BCD_DIGITS   = 5;
    localparam int C_BCD_W        = 4 * C_BCD_DIGITS;
    localparam int C_STEP_W       = $clog2(C_MAG_W);
    localparam int C_CNT_W        = 4;
    localparam int C_SEG_W        = 8;
    localparam int C_DOT_W        = 3;
    localparam int C_CFG_IDX_W    = 2;
    localparam int C_CFG_DATA_W   = 8;

    localparam logic [C_CFG_IDX_W-1:0] CFG_DIGIT_COUNT = 2'd0;
    localparam logic [C_CFG_IDX_W-1:0] CFG_MINUS       = 2'd1;
    localparam logic [C_CFG_IDX_W-1:0] CFG_BLANK       = 2'd2;

    localparam logic [C_CNT_W-1:0] C_DIGIT_COUNT_RST = 4'd4;
    localparam logic [C_SEG_W-1:0] C_MINUS_RST       = 8'h40;
    localparam logic [C_SEG_W-1:0] C_BLANK_RST       = 8'h00;
    localparam logic [C_SEG_W-1:0] C_DOT_BIT         = 8'h80;

    typedef logic [3:0] t_nibble;
    typedef logic [C_SEG_W-1:0] t_seg;

    typedef struct packed {
        logic                 neg;
        logic                 left_align;
        logic                 punctuate;
        logic [C_DOT_W-1:0]   dot_position;
    } t_opts;

    function automatic t_seg seg_code(input t_nibble d);
        t_seg c;
        case (d)
            4'd0: c = 8'b00111111;
            4'd1: c = 8'b00000110;
            4'd2: c = 8'b01011011;
            4'd3: c = 8'b01001111;
            4'd4: c = 8'b01100110;
            4'd5: c = 8'b01101101;
            4'd6: c = 8'b01111101;
            4'd7: c = 8'b00000111;
            4'd8: c = 8'b01111111;
            4'd9: c = 8'b01101111;
            default: c = 8'b00000000;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

FILE: src/ssd_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssd_in_if / ssd_out_if
// Valid-ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface ssd_in_if;
    logic                            valid;
    logic                            ready;
    logic signed [ssd_pkg::C_MAG_W-1:0] value;
    logic                            left_align;
    logic                            punctuate;
    logic [ssd_pkg::C_DOT_W-1:0]     dot_position;

    modport source (output valid, value, left_align, punctuate, dot_position,
                    input ready);
    modport sink   (input valid, value, left_align, punctuate, dot_position,
                    output ready);
endinterface

interface ssd_out_if #(
    parameter int MAX_DIGITS = ssd_pkg::MAX_DIGITS
);
    logic                                     valid;
    logic                                     ready;
    logic [ssd_pkg::C_SEG_W*MAX_DIGITS-1:0]   segments_packed;
    logic                                     fits;

    modport source (output valid, segments_packed, fits, input ready);
    modport sink   (input valid, segments_packed, fits, output ready);
endinterface
`default_nettype wire

FILE: src/ssd_dabble.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssd_dabble
// Shift-and-add-3 binary to BCD converter, one magnitude bit per cycle.
// ----------------------------------------------------------------------------
module ssd_dabble (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_start,
    input  wire logic [ssd_pkg::C_MAG_W-1:0]     i_mag,
    output logic                                 o_done,
    output logic [ssd_pkg::C_BCD_W-1:0]          o_bcd
);

    logic [ssd_pkg::C_MAG_W-1:0]  r_bin;
    logic [ssd_pkg::C_BCD_W-1:0]  r_bcd, n_adj;
    logic [ssd_pkg::C_STEP_W-1:0] r_cnt;
    logic                         r_busy;
    logic                         r_done;

    always_comb begin
        for (int i = 0; i < ssd_pkg::C_BCD_DIGITS; i++) begin
            if (r_bcd[4*i +: 4] >= 4'd5) begin
                n_adj[4*i +: 4] = r_bcd[4*i +: 4] + 4'd3;
            end else begin
                n_adj[4*i +: 4] = r_bcd[4*i +: 4];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == ssd_pkg::C_STEP_W'(ssd_pkg::C_MAG_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_bin <= i_mag;
            r_bcd <= '0;
        end else if (r_busy) begin
            r_bin <= {r_bin[ssd_pkg::C_MAG_W-2:0], 1'b0};
            r_bcd <= {n_adj[ssd_pkg::C_BCD_W-2:0], r_bin[ssd_pkg::C_MAG_W-1]};
        end
    end

    assign o_done = r_done;
    assign o_bcd  = r_bcd;

endmodule
`default_nettype wire

FILE: src/ssd_format.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssd_format
// Places digits, minus sign, dot and blanks into the display positions.
// ----------------------------------------------------------------------------
module ssd_format #(
    parameter int MAX_DIGITS = ssd_pkg::MAX_DIGITS
) (
    input  wire logic [ssd_pkg::C_BCD_W-1:0]            i_bcd,
    input  wire ssd_pkg::t_opts                         i_opts,
    input  wire logic [ssd_pkg::C_CNT_W-1:0]            i_digit_count,
    input  wire ssd_pkg::t_seg                          i_minus,
    input  wire ssd_pkg::t_seg                          i_blank,
    output logic [ssd_pkg::C_SEG_W*MAX_DIGITS-1:0]      o_segments,
    output logic                                        o_fits
);

    logic [ssd_pkg::C_CNT_W-1:0] n_eff;
    logic [ssd_pkg::C_CNT_W-1:0] n_digits;
    logic [ssd_pkg::C_CNT_W-1:0] n_len;

    always_comb begin
        if (i_digit_count > ssd_pkg::C_CNT_W'(MAX_DIGITS)) begin
            n_eff = ssd_pkg::C_CNT_W'(MAX_DIGITS);
        end else begin
            n_eff = i_digit_count;
        end
        n_digits = 4'd1;
        for (int i = 1; i < ssd_pkg::C_BCD_DIGITS; i++) begin
            if (i_bcd[4*i +: 4] != 4'd0) begin
                n_digits = ssd_pkg::C_CNT_W'(i + 1);
            end
        end
        n_len  = n_digits + ssd_pkg::C_CNT_W'(i_opts.neg);
        o_fits = (n_eff != '0) && (n_len <= n_eff);
    end

    for (genvar k = 0; k < MAX_DIGITS; k++) begin : g_lane
        logic [ssd_pkg::C_CNT_W-1:0] n_pos;
        logic [ssd_pkg::C_CNT_W-1:0] n_j;
        logic                        n_on_text;
        ssd_pkg::t_seg               n_char;

        always_comb begin
            n_pos = ssd_pkg::C_CNT_W'(k);
            if (i_opts.left_align) begin
                n_on_text = n_pos < n_len;
                n_j       = n_len - 1'b1 - n_pos;
            end else begin
                n_on_text = (n_pos < n_eff) && (n_pos + n_len >= n_eff);
                n_j       = n_eff - 1'b1 - n_pos;
            end
            if (n_j < n_digits) begin
                n_char = ssd_pkg::seg_code(i_bcd[4*n_j[2:0] +: 4]);
            end else begin
                n_char = i_minus;
            end
            if (i_opts.punctuate && (n_j == ssd_pkg::C_CNT_W'(i_opts.dot_position))) begin
                n_char = n_char | ssd_pkg::C_DOT_BIT;
            end
            if (!o_fits || (n_pos >= n_eff)) begin
                o_segments[ssd_pkg::C_SEG_W*k +: ssd_pkg::C_SEG_W] = '0;
            end else if (n_on_text) begin
                o_segments[ssd_pkg::C_SEG_W*k +: ssd_pkg::C_SEG_W] = n_char;
            end else begin
                o_segments[ssd_pkg::C_SEG_W*k +: ssd_pkg::C_SEG_W] = i_blank;
            end
        end
    end

endmodule
`default_nettype wire

FILE: src/signed_number_to_seven_segment_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// signed_number_to_seven_segment_top
// Formats a signed 16-bit number as seven-segment codes.
// ----------------------------------------------------------------------------
// Steps: an accepted item starts 16 converter steps of one magnitude bit each;
// the registered done flag hands over the digits, the formatting state loads the
// result register, and only then does the input open again, so no new item is
// taken before the last is through; a stalled result holds the formatting step.
// Reset (synchronous, active low) restores the register defaults and empties
// the result register.
module signed_number_to_seven_segment_top #(
    parameter int MAX_DIGITS = ssd_pkg::MAX_DIGITS
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_we,
    input  wire logic [ssd_pkg::C_CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [ssd_pkg::C_CFG_DATA_W-1:0]     i_cfg_data,
    ssd_in_if.sink                                    i_item,
    ssd_out_if.source                                 o_result
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CONV = 2'd1;
    localparam logic [1:0] S_FMT  = 2'd2;

    logic [1:0]                              r_state;
    logic [ssd_pkg::C_CNT_W-1:0]             r_digit_count;
    ssd_pkg::t_seg                           r_minus;
    ssd_pkg::t_seg                           r_blank;
    ssd_pkg::t_opts                          r_opts;
    logic                                    r_out_valid;
    logic [ssd_pkg::C_SEG_W*MAX_DIGITS-1:0]  r_out_seg;
    logic                                    r_out_fits;

    logic                                    n_accept;
    logic [ssd_pkg::C_MAG_W-1:0]             n_mag;
    logic                                    n_done;
    logic [ssd_pkg::C_BCD_W-1:0]             n_bcd;
    logic [ssd_pkg::C_SEG_W*MAX_DIGITS-1:0]  n_seg;
    logic                                    n_fits;
    logic                                    n_load;

    assign i_item.ready = (r_state == S_IDLE);
    assign n_accept     = i_item.valid && i_item.ready;
    assign n_mag        = i_item.value[ssd_pkg::C_MAG_W-1] ?
                          (~i_item.value + 1'b1) : i_item.value;
    assign n_load       = (r_state == S_FMT) && (!r_out_valid || o_result.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digit_count <= ssd_pkg::C_DIGIT_COUNT_RST;
            r_minus       <= ssd_pkg::C_MINUS_RST;
            r_blank       <= ssd_pkg::C_BLANK_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ssd_pkg::CFG_DIGIT_COUNT: r_digit_count <= i_cfg_data[ssd_pkg::C_CNT_W-1:0];
                ssd_pkg::CFG_MINUS:       r_minus       <= i_cfg_data;
                ssd_pkg::CFG_BLANK:       r_blank       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (n_load) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (n_accept) begin
                        r_state <= S_CONV;
                    end
                end
                S_CONV: begin
                    if (n_done) begin
                        r_state <= S_FMT;
                    end
                end
                S_FMT: begin
                    if (n_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_accept) begin
            r_opts.neg          <= i_item.value[ssd_pkg::C_MAG_W-1];
            r_opts.left_align   <= i_item.left_align;
            r_opts.punctuate    <= i_item.punctuate;
            r_opts.dot_position <= i_item.dot_position;
        end
        if (n_load) begin
            r_out_seg  <= n_seg;
            r_out_fits <= n_fits;
        end
    end

    ssd_dabble u_dabble (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (n_accept),
        .i_mag   (n_mag),
        .o_done  (n_done),
        .o_bcd   (n_bcd)
    );

    ssd_format #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_format (
        .i_bcd         (n_bcd),
        .i_opts        (r_opts),
        .i_digit_count (r_digit_count),
        .i_minus       (r_minus),
        .i_blank       (r_blank),
        .o_segments    (n_seg),
        .o_fits        (n_fits)
    );

    assign o_result.valid           = r_out_valid;
    assign o_result.segments_packed = r_out_seg;
    assign o_result.fits            = r_out_fits;

endmodule
`default_nettype wire

FILE: src/ssd_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssd_checker
// Port-level checks of the formatter, attached to the top level.
// ----------------------------------------------------------------------------
module ssd_checker #(
    parameter int MAX_DIGITS = ssd_pkg::MAX_DIGITS
) (
    input wire logic                                 i_clk,
    input wire logic                                 i_rst_n,
    input wire logic                                 i_in_valid,
    input wire logic                                 i_in_ready,
    input wire logic                                 i_out_valid,
    input wire logic                                 i_out_ready,
    input wire logic [ssd_pkg::C_SEG_W*MAX_DIGITS-1:0] i_out_segments,
    input wire logic                                 i_out_fits
);

    // The input closes for the whole conversion once an item is taken.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input ready right after an accepted item");

    a_busy_mid_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |-> ##8 (!i_in_ready && !$rose(i_out_valid)))
        else $error("conversion ended too early");

    // A text that does not fit shows no segments.
    a_no_fit_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_fits) |-> (i_out_segments == '0))
        else $error("segments set on a result that does not fit");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_segments)
                                          && $stable(i_out_fits)))
        else $error("stalled result changed");

endmodule

bind signed_number_to_seven_segment_top ssd_checker #(
    .MAX_DIGITS (MAX_DIGITS)
) u_ssd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_item.valid),
    .i_in_ready     (i_item.ready),
    .i_out_valid    (o_result.valid),
    .i_out_ready    (o_result.ready),
    .i_out_segments (o_result.segments_packed),
    .i_out_fits     (o_result.fits)
);
`default_nettype wire
